// ===== rtl/vadsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Voice allocator package
// Shared types, constants and the envelope step function of the voice
// allocator with linear ADSR envelopes.
// ----------------------------------------------------------------------------
package vadsr_pkg;

  localparam int LEVEL_W    = 16;
  localparam int NOTE_W     = 7;
  localparam int VOICE_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int MAXV_W     = 5;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_VOICE_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP  = 3'd4;

  localparam logic [MAXV_W-1:0]  RST_VOICE_LIMIT   = 5'd16;
  localparam logic [LEVEL_W-1:0] RST_ATTACK_STEP   = 16'd137;
  localparam logic [LEVEL_W-1:0] RST_DECAY_STEP    = 16'd14;
  localparam logic [LEVEL_W-1:0] RST_SUSTAIN_LEVEL = 16'd45875;
  localparam logic [LEVEL_W-1:0] RST_RELEASE_STEP  = 16'd5;

  typedef enum logic [1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_ALL_OFF  = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch a new request and arm the scan
    logic scan;      // scan pass over the voice table is running
    logic emit;      // commit a single-result request and load the result
    logic rpt_clr;   // rewind the voice index for the tick report pass
    logic rpt_load;  // load one tick report result
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic scan_done;
    logic out_free;
    logic rpt_last;
  } sts_t;

  // One envelope step of an active voice.
  function automatic logic [LEVEL_W-1:0] env_next(
    input logic [LEVEL_W-1:0] lv,
    input logic               gate,
    input logic [LEVEL_W-1:0] att,
    input logic [LEVEL_W-1:0] dec,
    input logic [LEVEL_W-1:0] sus,
    input logic [LEVEL_W-1:0] rel
  );
    logic [LEVEL_W:0]   sum;
    logic [LEVEL_W-1:0] diff;
    logic [LEVEL_W-1:0] res;
    sum  = {1'b0, lv} + {1'b0, att};
    diff = lv - sus;
    res  = lv;
    if (gate) begin
      if (lv != FULL_SCALE) begin
        res = (sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : sum[LEVEL_W-1:0];
      end else if (lv > sus) begin
        res = (diff < dec) ? sus : lv - dec;
      end
    end else if (lv != '0) begin
      res = (lv < rel) ? '0 : lv - rel;
    end
    return res;
  endfunction

endpackage

// ===== rtl/vadsr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module vadsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/vadsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Voice allocator controller
// Sequences the scan, commit and report steps of each request.
// ----------------------------------------------------------------------------
module vadsr_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [1:0]              in_cmd,
  input  vadsr_pkg::sts_t         sts,
  output vadsr_pkg::ctl_t         ctl,
  output logic                    in_stall
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_RPT_RD,
    S_RPT_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_nxt  = (in_cmd == vadsr_pkg::CMD_ALL_OFF) ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) begin
          if (sts.cmd == vadsr_pkg::CMD_TICK) begin
            ctl.rpt_clr = 1'b1;
            state_nxt   = S_RPT_RD;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RPT_RD: begin
        state_nxt = S_RPT_OUT;
      end
      S_RPT_OUT: begin
        if (sts.out_free) begin
          ctl.rpt_load = 1'b1;
          state_nxt    = sts.rpt_last ? S_IDLE : S_RPT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

// ===== rtl/vadsr_dp.sv =====
// ----------------------------------------------------------------------------
// Voice allocator datapath
// Configuration registers, voice flags, the note and level RAM, the scan
// logic for allocation, release and envelope update, and the result register.
// ----------------------------------------------------------------------------
module vadsr_dp #(
  parameter int NUM_VOICES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [vadsr_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [vadsr_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [1:0]                            in_cmd,
  input  logic [vadsr_pkg::NOTE_W-1:0]          in_note,
  input  logic                                  out_stall,
  input  vadsr_pkg::ctl_t                       ctl,
  output vadsr_pkg::sts_t                       sts,
  output logic                                  out_valid,
  output logic [vadsr_pkg::VOICE_W-1:0]         out_voice,
  output logic [vadsr_pkg::LEVEL_W-1:0]         out_level,
  output logic                                  out_is_active,
  output logic                                  out_is_gated,
  output logic                                  out_found,
  output logic                                  out_stolen,
  output logic [vadsr_pkg::COUNT_W-1:0]         out_active_count,
  output logic                                  out_last
);

  localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW = $clog2(NUM_VOICES + 1);
  localparam int LW = vadsr_pkg::LEVEL_W;
  localparam int NW = vadsr_pkg::NOTE_W;
  localparam int RW = NW + LW;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_VOICES - 1);

  // Configuration registers.
  logic [vadsr_pkg::MAXV_W-1:0] voice_limit_r;
  logic [LW-1:0] attack_r, decay_r, sustain_r, release_r;

  // Voice flags and active count.
  logic [NUM_VOICES-1:0] active_r, active_nxt;
  logic [NUM_VOICES-1:0] gate_r, gate_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;

  // Request and scan state.
  vadsr_pkg::cmd_t cmd_r, cmd_nxt;
  logic [NW-1:0]   note_r, note_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic            rd_more_r, rd_more_nxt;
  logic            ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]   ev_idx_r, ev_idx_nxt;
  logic            found_r, found_nxt;
  logic [IW-1:0]   pick_r, pick_nxt;
  logic [IW-1:0]   spick_r, spick_nxt;
  logic [LW-1:0]   low_r, low_nxt;
  logic [LW-1:0]   lvl_r, lvl_nxt;

  // Result register.
  logic                           ov_r, ov_nxt;
  logic [vadsr_pkg::VOICE_W-1:0]  o_voice_r, o_voice_nxt;
  logic [LW-1:0]                  o_level_r, o_level_nxt;
  logic                           o_act_r, o_act_nxt;
  logic                           o_gate_r, o_gate_nxt;
  logic                           o_found_r, o_found_nxt;
  logic                           o_stolen_r, o_stolen_nxt;
  logic [vadsr_pkg::COUNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic                           o_last_r, o_last_nxt;

  // RAM ports.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  // Scan helpers.
  logic [6:0]    lim;
  logic [IW-1:0] on_last;
  logic [IW-1:0] scan_last;
  logic [NW-1:0] rd_note;
  logic [LW-1:0] rd_level;
  logic          ev_act, ev_gate, ev_on, match;
  logic [LW-1:0] new_level;
  logic [IW-1:0] sel_pick;
  logic          was;
  logic          out_free;

  vadsr_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_VOICES),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Enabled voice limit: zero acts as one, anything above the table size
  // acts as the table size.
  always_comb begin
    lim = {2'b00, voice_limit_r};
    if (voice_limit_r == '0) begin
      lim = 7'd1;
    end else if (lim > 7'(NUM_VOICES)) begin
      lim = 7'(NUM_VOICES);
    end
    on_last = IW'(lim - 7'd1);
  end

  assign scan_last = (cmd_r == vadsr_pkg::CMD_NOTE_ON) ? on_last : LAST_IDX;
  assign rd_note   = ram_rdata[RW-1:LW];
  assign rd_level  = ram_rdata[LW-1:0];
  assign ev_act    = active_r[ev_idx_r];
  assign ev_gate   = gate_r[ev_idx_r];
  assign ev_on     = ctl.scan && ev_vld_r;
  assign match     = ev_act && ev_gate && (rd_note == note_r);
  assign new_level = vadsr_pkg::env_next(rd_level, ev_gate, attack_r, decay_r,
                                         sustain_r, release_r);
  assign sel_pick  = found_r ? pick_r : spick_r;
  assign was       = active_r[sel_pick];
  assign out_free  = !ov_r || !out_stall;

  assign sts.cmd       = cmd_r;
  assign sts.scan_done = ev_on && (((cmd_r == vadsr_pkg::CMD_NOTE_OFF) && match) ||
                                   (ev_idx_r == scan_last));
  assign sts.out_free  = out_free;
  assign sts.rpt_last  = (idx_r == LAST_IDX);

  always_comb begin
    active_nxt   = active_r;
    gate_nxt     = gate_r;
    cnt_nxt      = cnt_r;
    cmd_nxt      = cmd_r;
    note_nxt     = note_r;
    idx_nxt      = idx_r;
    rd_more_nxt  = rd_more_r;
    ev_vld_nxt   = ctl.scan && rd_more_r;
    ev_idx_nxt   = idx_r;
    found_nxt    = found_r;
    pick_nxt     = pick_r;
    spick_nxt    = spick_r;
    low_nxt      = low_r;
    lvl_nxt      = lvl_r;
    ram_we       = 1'b0;
    ram_waddr    = ev_idx_r;
    ram_wdata    = {rd_note, new_level};
    ov_nxt       = ov_r && out_stall;
    o_voice_nxt  = o_voice_r;
    o_level_nxt  = o_level_r;
    o_act_nxt    = o_act_r;
    o_gate_nxt   = o_gate_r;
    o_found_nxt  = o_found_r;
    o_stolen_nxt = o_stolen_r;
    o_cnt_nxt    = o_cnt_r;
    o_last_nxt   = o_last_r;

    if (ctl.accept) begin
      cmd_nxt     = vadsr_pkg::cmd_t'(in_cmd);
      note_nxt    = in_note;
      idx_nxt     = '0;
      rd_more_nxt = 1'b1;
      found_nxt   = 1'b0;
      pick_nxt    = '0;
      spick_nxt   = '0;
      low_nxt     = vadsr_pkg::FULL_SCALE;
    end

    if (ctl.scan) begin
      // Read side runs one voice ahead of the evaluation side.
      if (rd_more_r) begin
        if (idx_r == scan_last) begin
          rd_more_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      if (ev_vld_r) begin
        unique case (cmd_r)
          vadsr_pkg::CMD_NOTE_ON: begin
            if (!found_r && !ev_act) begin
              found_nxt = 1'b1;
              pick_nxt  = ev_idx_r;
            end else if (ev_act && (rd_level < low_r)) begin
              low_nxt   = rd_level;
              spick_nxt = ev_idx_r;
            end
          end
          vadsr_pkg::CMD_NOTE_OFF: begin
            if (match) begin
              found_nxt = 1'b1;
              pick_nxt  = ev_idx_r;
              lvl_nxt   = rd_level;
            end
          end
          default: begin
            // Tick: envelope update of active voices, free finished ones.
            if (ev_act) begin
              ram_we = 1'b1;
              if (!ev_gate && (new_level == '0)) begin
                active_nxt[ev_idx_r] = 1'b0;
                cnt_nxt              = cnt_r - CW'(1);
              end
            end
          end
        endcase
      end
    end

    if (ctl.emit) begin
      ov_nxt       = 1'b1;
      o_voice_nxt  = '0;
      o_level_nxt  = '0;
      o_act_nxt    = 1'b0;
      o_gate_nxt   = 1'b0;
      o_found_nxt  = 1'b0;
      o_stolen_nxt = 1'b0;
      o_cnt_nxt    = vadsr_pkg::COUNT_W'(cnt_r);
      o_last_nxt   = 1'b1;
      unique case (cmd_r)
        vadsr_pkg::CMD_NOTE_ON: begin
          ram_we               = 1'b1;
          ram_waddr            = sel_pick;
          ram_wdata            = {note_r, {LW{1'b0}}};
          active_nxt[sel_pick] = 1'b1;
          gate_nxt[sel_pick]   = 1'b1;
          cnt_nxt              = cnt_r + CW'(!was);
          o_voice_nxt          = vadsr_pkg::VOICE_W'(sel_pick);
          o_act_nxt            = 1'b1;
          o_gate_nxt           = 1'b1;
          o_found_nxt          = 1'b1;
          o_stolen_nxt         = was;
          o_cnt_nxt            = vadsr_pkg::COUNT_W'(cnt_r + CW'(!was));
        end
        vadsr_pkg::CMD_NOTE_OFF: begin
          if (found_r) begin
            gate_nxt[pick_r] = 1'b0;
            o_voice_nxt      = vadsr_pkg::VOICE_W'(pick_r);
            o_level_nxt      = lvl_r;
            o_act_nxt        = 1'b1;
            o_found_nxt      = 1'b1;
          end
        end
        vadsr_pkg::CMD_ALL_OFF: begin
          gate_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    if (ctl.rpt_clr) begin
      idx_nxt = '0;
    end

    if (ctl.rpt_load) begin
      // Inactive voices always report level zero.
      ov_nxt       = 1'b1;
      o_voice_nxt  = vadsr_pkg::VOICE_W'(idx_r);
      o_level_nxt  = active_r[idx_r] ? rd_level : '0;
      o_act_nxt    = active_r[idx_r];
      o_gate_nxt   = gate_r[idx_r];
      o_found_nxt  = 1'b0;
      o_stolen_nxt = 1'b0;
      o_cnt_nxt    = vadsr_pkg::COUNT_W'(cnt_r);
      o_last_nxt   = (idx_r == LAST_IDX);
      idx_nxt      = idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_limit_r <= vadsr_pkg::RST_VOICE_LIMIT;
      attack_r      <= vadsr_pkg::RST_ATTACK_STEP;
      decay_r       <= vadsr_pkg::RST_DECAY_STEP;
      sustain_r     <= vadsr_pkg::RST_SUSTAIN_LEVEL;
      release_r     <= vadsr_pkg::RST_RELEASE_STEP;
      active_r      <= '0;
      gate_r        <= '0;
      cnt_r         <= '0;
      rd_more_r     <= 1'b0;
      ev_vld_r      <= 1'b0;
      ov_r          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          vadsr_pkg::CFG_VOICE_LIMIT:   voice_limit_r <= cfg_wdata[vadsr_pkg::MAXV_W-1:0];
          vadsr_pkg::CFG_ATTACK_STEP:   attack_r      <= cfg_wdata;
          vadsr_pkg::CFG_DECAY_STEP:    decay_r       <= cfg_wdata;
          vadsr_pkg::CFG_SUSTAIN_LEVEL: sustain_r     <= cfg_wdata;
          vadsr_pkg::CFG_RELEASE_STEP:  release_r     <= cfg_wdata;
          default: begin
          end
        endcase
      end
      active_r  <= active_nxt;
      gate_r    <= gate_nxt;
      cnt_r     <= cnt_nxt;
      rd_more_r <= rd_more_nxt;
      ev_vld_r  <= ev_vld_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    note_r     <= note_nxt;
    idx_r      <= idx_nxt;
    ev_idx_r   <= ev_idx_nxt;
    found_r    <= found_nxt;
    pick_r     <= pick_nxt;
    spick_r    <= spick_nxt;
    low_r      <= low_nxt;
    lvl_r      <= lvl_nxt;
    o_voice_r  <= o_voice_nxt;
    o_level_r  <= o_level_nxt;
    o_act_r    <= o_act_nxt;
    o_gate_r   <= o_gate_nxt;
    o_found_r  <= o_found_nxt;
    o_stolen_r <= o_stolen_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid        = ov_r;
  assign out_voice        = o_voice_r;
  assign out_level        = o_level_r;
  assign out_is_active    = o_act_r;
  assign out_is_gated     = o_gate_r;
  assign out_found        = o_found_r;
  assign out_stolen       = o_stolen_r;
  assign out_active_count = o_cnt_r;
  assign out_last         = o_last_r;

  // The running count must always agree with the active flags.
  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CW'($countones(active_r)))
    else $error("active count out of step with active flags");

  // A gated voice is always active.
  a_gate_in_active: assert property (@(posedge clk) disable iff (!rst_n)
    (gate_r & ~active_r) == '0)
    else $error("gate set on an inactive voice");

  // A result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit || ctl.rpt_load) |-> !(ov_r && out_stall))
    else $error("result register overwritten while stalled");

  // Evaluation only happens inside a scan pass.
  a_ev_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev_vld_r |-> $past(ctl.scan))
    else $error("scan evaluation outside a scan pass");

endmodule

// ===== rtl/voice_allocator_with_adsr_top.sv =====
// ----------------------------------------------------------------------------
// Voice allocator with linear ADSR envelopes
// Polyphonic voice table with allocation, stealing, release and a per-voice
// linear attack, decay, sustain and release amplitude envelope.
// ----------------------------------------------------------------------------
// The block takes one request at a time: note on, note off, all notes off or
// tick. Voice notes and envelope levels live in a single-port-read RAM, so
// note on, note off and tick requests walk the voice table one voice per
// cycle. A note on scans the enabled voices; it picks the first free voice
// or steals the quietest voice below full scale. A note off scans up to
// NUM_VOICES voices and stops early at the first match. All notes off does
// not scan the table. A tick runs one update pass at one voice per cycle,
// then a report pass that reads and then returns each voice in turn,
// because the active count in every result is only known once all voices
// have been updated. Single-result requests return one result; a tick
// returns NUM_VOICES results in voice order, with last set on the final one.
// A new request is accepted while the previous result still waits in the
// output register. Configuration registers may only be written while the
// block is idle.
// ----------------------------------------------------------------------------
module voice_allocator_with_adsr_top #(
  parameter int NUM_VOICES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [vadsr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [vadsr_pkg::CFG_W-1:0]       cfg_wdata,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_cmd,
  input  logic [vadsr_pkg::NOTE_W-1:0]      in_note,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vadsr_pkg::VOICE_W-1:0]     out_voice,
  output logic [vadsr_pkg::LEVEL_W-1:0]     out_level,
  output logic                              out_is_active,
  output logic                              out_is_gated,
  output logic                              out_found,
  output logic                              out_stolen,
  output logic [vadsr_pkg::COUNT_W-1:0]     out_active_count,
  output logic                              out_last
);

  // Commands and status between the controller and the datapath.
  vadsr_pkg::ctl_t ctl;
  vadsr_pkg::sts_t sts;

  // The controller sequences scan, commit and report steps.
  vadsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .sts      (sts),
    .ctl      (ctl),
    .in_stall (in_stall)
  );

  // The datapath holds the voice table, envelope logic and result register.
  vadsr_dp #(
    .NUM_VOICES (NUM_VOICES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_cmd),
    .in_note          (in_note),
    .out_stall        (out_stall),
    .ctl              (ctl),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_voice        (out_voice),
    .out_level        (out_level),
    .out_is_active    (out_is_active),
    .out_is_gated     (out_is_gated),
    .out_found        (out_found),
    .out_stolen       (out_stolen),
    .out_active_count (out_active_count),
    .out_last         (out_last)
  );

endmodule
